>>> rtl/core/scft_pkg.sv
// Shared types, constants and helpers for the command frame tokenizer.
package scft_pkg;

  localparam int WINDOW_DEF      = 64;
  localparam int TOKEN_LIMIT_DEF = 8;

  // Field widths sized for the largest window (64) and token limit (16).
  localparam int PTR_W = 6;
  localparam int CNT_W = 7;
  localparam int TOK_W = 5;
  localparam int NUM_W = 4;

  localparam int JOBQ_DEPTH = 2;
  localparam int JQ_PTR_W   = 1;
  localparam int JQ_CNT_W   = 2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DASH   = 8'h2D;

  localparam logic ERR_BAD_FRAME = 1'b0;
  localparam logic ERR_NO_TOKENS = 1'b1;

  // Snapshot of the window taken when a '>' is written.
  typedef struct packed {
    logic [PTR_W-1:0] head;
    logic [CNT_W-1:0] fill;
    logic [CNT_W-1:0] dash;
  } job_t;

  typedef struct packed {
    logic valid;
    logic ok;
  } done_t;

  typedef struct packed {
    logic             is_error;
    logic             error_code;
    logic [7:0]       token_char;
    logic [NUM_W-1:0] token_number;
    logic             token_end;
    logic             frame_end;
  } res_t;

  function automatic logic is_delim(input logic [7:0] c);
    return (c == CH_LPAREN) || (c == CH_COMMA) || (c == CH_RPAREN);
  endfunction

endpackage

>>> rtl/core/scft_front.sv
// Front end: byte filter, circular character window and frame job launch.
module scft_front import scft_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] rx_byte
  output logic             job_valid,
  input  logic             job_ready,
  output job_t             job,
  input  done_t            done,
  input  logic [PTR_W-1:0] rd_addr,
  output logic [7:0]       rd_data
);

  localparam int AW = $clog2(WINDOW);

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] dash_r, dash_nxt;
  logic             busy_r, busy_nxt;

  logic [7:0]       mem [WINDOW];
  logic [7:0]       rd_data_r;

  logic             accept;
  logic             keep;
  logic             full;
  logic [CNT_W-1:0] wsum;
  logic [PTR_W-1:0] wr_addr;
  logic [PTR_W-1:0] head_inc;

  assign in_tready = !busy_r && job_ready;
  assign accept    = in_tvalid && in_tready;
  assign keep      = (in_tdata != CH_NUL) && (in_tdata != CH_LF) && (in_tdata != CH_CR);
  assign full      = (fill_r == CNT_W'(WINDOW));

  always_comb begin
    wsum = CNT_W'(head_r) + fill_r;
    if (wsum >= CNT_W'(WINDOW)) begin
      wsum = wsum - CNT_W'(WINDOW);
    end
    wr_addr  = full ? head_r : wsum[PTR_W-1:0];
    head_inc = (head_r == PTR_W'(WINDOW - 1)) ? '0 : head_r + PTR_W'(1);
  end

  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    dash_nxt = dash_r;
    busy_nxt = busy_r;
    if (accept && keep) begin
      if (full) begin
        // oldest character drops out; a leading dash goes with it
        head_nxt = head_inc;
        dash_nxt = (dash_r != '0) ? dash_r - CNT_W'(1) : '0;
      end else begin
        fill_nxt = fill_r + CNT_W'(1);
      end
      if (in_tdata == CH_GT) begin
        busy_nxt = 1'b1;
      end
    end
    if (done.valid) begin
      busy_nxt = 1'b0;
      if (done.ok) begin
        // refill with dashes: every slot reads as '-' until new characters push them out
        fill_nxt = CNT_W'(WINDOW);
        dash_nxt = CNT_W'(WINDOW);
      end
    end
  end

  assign job_valid = accept && keep && (in_tdata == CH_GT);
  assign job       = '{head: head_nxt, fill: fill_nxt, dash: dash_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
      dash_r <= '0;
      busy_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
      dash_r <= dash_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      mem[wr_addr[AW-1:0]] <= in_tdata;
    end
    rd_data_r <= mem[rd_addr[AW-1:0]];
  end

  assign rd_data = rd_data_r;

  a_fill_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r <= CNT_W'(WINDOW)) && (dash_r <= fill_r))
    else $error("window fill or dash count out of range");

  a_done_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done.valid |-> busy_r)
    else $error("frame completion without a frame in flight");

endmodule

>>> rtl/core/scft_jobq.sv
// Small job FIFO between the front end and the frame scanner.
module scft_jobq import scft_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);

  job_t                entries [JOBQ_DEPTH];
  logic [JQ_PTR_W-1:0] wr_ptr_r;
  logic [JQ_PTR_W-1:0] rd_ptr_r;
  logic [JQ_CNT_W-1:0] count_r;
  logic                push;
  logic                pop;

  assign push_ready = (count_r != JQ_CNT_W'(JOBQ_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entries[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + JQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + JQ_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + JQ_CNT_W'(1);
        2'b01:   count_r <= count_r - JQ_CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= JQ_CNT_W'(JOBQ_DEPTH))
    else $error("job queue count above depth");

endmodule

>>> rtl/core/scft_back.sv
// Back end: finds the opening '<', splits the frame into tokens, emits results.
module scft_back import scft_pkg::*; #(
  parameter int WINDOW      = WINDOW_DEF,
  parameter int TOKEN_LIMIT = TOKEN_LIMIT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  output logic             job_ready,
  input  job_t             job,
  output logic [PTR_W-1:0] rd_addr,
  input  logic [7:0]       rd_data,
  output done_t            done,
  output logic             out_valid,
  input  logic             out_ready,
  output res_t             out_res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRD,
    S_SCHK,
    S_ERR,
    S_TRD,
    S_TCHK
  } state_t;

  state_t           state_r;
  logic [PTR_W-1:0] head_r;
  logic [PTR_W-1:0] end_r;
  logic [CNT_W-1:0] dash_r;
  logic [PTR_W-1:0] i_r;
  logic [TOK_W-1:0] tokens_r;
  logic             pend_valid_r;
  logic             pend_closed_r;
  logic [7:0]       pend_char_r;
  logic [NUM_W-1:0] pend_num_r;
  logic             err_code_r;
  logic             out_valid_r;
  res_t             out_res_r;
  done_t            done_r;

  logic [CNT_W-1:0] asum;
  logic [7:0]       cur_c;
  logic             can_load;
  logic             at_limit;

  // logical index -> physical slot of the circular window
  always_comb begin
    asum = CNT_W'(head_r) + CNT_W'(i_r);
    if (asum >= CNT_W'(WINDOW)) begin
      asum = asum - CNT_W'(WINDOW);
    end
  end

  assign rd_addr   = asum[PTR_W-1:0];
  assign cur_c     = (CNT_W'(i_r) < dash_r) ? CH_DASH : rd_data;
  assign can_load  = !out_valid_r || out_ready;
  assign at_limit  = ((tokens_r + TOK_W'(1)) == TOK_W'(TOKEN_LIMIT));
  assign job_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign done      = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      done_r       <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      done_r <= '0;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            head_r     <= job.head;
            dash_r     <= job.dash;
            end_r      <= PTR_W'(job.fill - CNT_W'(1));
            err_code_r <= ERR_BAD_FRAME;
            if (job.fill <= CNT_W'(1)) begin
              state_r <= S_ERR;
            end else begin
              i_r     <= PTR_W'(job.fill - CNT_W'(2));
              state_r <= S_SRD;
            end
          end
        end
        S_SRD: begin
          state_r <= S_SCHK;
        end
        S_SCHK: begin
          if (cur_c == CH_LT) begin
            if ((CNT_W'(i_r) + CNT_W'(1)) == CNT_W'(end_r)) begin
              state_r <= S_ERR;
            end else begin
              i_r           <= i_r + PTR_W'(1);
              tokens_r      <= '0;
              pend_valid_r  <= 1'b0;
              pend_closed_r <= 1'b0;
              state_r       <= S_TRD;
            end
          end else if (i_r == '0) begin
            state_r <= S_ERR;
          end else begin
            i_r     <= i_r - PTR_W'(1);
            state_r <= S_SRD;
          end
        end
        S_ERR: begin
          if (can_load) begin
            out_valid_r <= 1'b1;
            out_res_r   <= '{is_error: 1'b1, error_code: err_code_r, token_char: 8'h00,
                             token_number: '0, token_end: 1'b0, frame_end: 1'b1};
            done_r      <= '{valid: 1'b1, ok: 1'b0};
            state_r     <= S_IDLE;
          end
        end
        S_TRD: begin
          if (i_r == end_r) begin
            if (pend_valid_r) begin
              if (can_load) begin
                out_valid_r  <= 1'b1;
                out_res_r    <= '{is_error: 1'b0, error_code: ERR_BAD_FRAME,
                                  token_char: pend_char_r, token_number: pend_num_r,
                                  token_end: 1'b1, frame_end: 1'b1};
                pend_valid_r <= 1'b0;
                done_r       <= '{valid: 1'b1, ok: 1'b1};
                state_r      <= S_IDLE;
              end
            end else begin
              err_code_r <= ERR_NO_TOKENS;
              state_r    <= S_ERR;
            end
          end else begin
            state_r <= S_TCHK;
          end
        end
        S_TCHK: begin
          if (is_delim(cur_c)) begin
            if (pend_valid_r && !pend_closed_r) begin
              if (at_limit) begin
                // last kept token closes here, the rest of the frame is skipped
                if (can_load) begin
                  out_valid_r  <= 1'b1;
                  out_res_r    <= '{is_error: 1'b0, error_code: ERR_BAD_FRAME,
                                    token_char: pend_char_r, token_number: pend_num_r,
                                    token_end: 1'b1, frame_end: 1'b1};
                  pend_valid_r <= 1'b0;
                  done_r       <= '{valid: 1'b1, ok: 1'b1};
                  state_r      <= S_IDLE;
                end
              end else begin
                // hold the closing char until we know whether another follows
                tokens_r      <= tokens_r + TOK_W'(1);
                pend_closed_r <= 1'b1;
                i_r           <= i_r + PTR_W'(1);
                state_r       <= S_TRD;
              end
            end else begin
              i_r     <= i_r + PTR_W'(1);
              state_r <= S_TRD;
            end
          end else if (!pend_valid_r || can_load) begin
            if (pend_valid_r) begin
              out_valid_r <= 1'b1;
              out_res_r   <= '{is_error: 1'b0, error_code: ERR_BAD_FRAME,
                               token_char: pend_char_r, token_number: pend_num_r,
                               token_end: pend_closed_r, frame_end: 1'b0};
            end
            pend_valid_r  <= 1'b1;
            pend_closed_r <= 1'b0;
            pend_char_r   <= cur_c;
            pend_num_r    <= tokens_r[NUM_W-1:0];
            i_r           <= i_r + PTR_W'(1);
            state_r       <= S_TRD;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_scan_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_TRD) || (state_r == S_TCHK)) |-> (i_r <= end_r))
    else $error("token scan ran past the terminator");

  a_pend_num: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (TOK_W'(pend_num_r) < TOK_W'(TOKEN_LIMIT)))
    else $error("pending token index beyond limit");

  a_done_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r.valid |-> ($past(state_r) != S_IDLE))
    else $error("frame completion while scanner idle");

endmodule

>>> rtl/core/serial_command_frame_tokenizer.sv
// Top level of the angle-bracket command frame tokenizer.
// Bytes arrive on the in_ stream; CR, LF and NUL are discarded and every other byte
// is kept in a sliding window of the last WINDOW characters. A '>' closes a frame:
// input then stalls while the scanner walks back through the window for the last '<'
// and then walks forward splitting the text at '(' ',' ')', with a read state and a
// check state per character each way for the registered window memory read, and
// emits one token character per out_ transfer. The token limit can end a frame early,
// and any output stall lengthens the input stall. A frame with no '<' or with nothing
// inside gives one error result, one with only delimiters gives a no-tokens error;
// out_tlast marks the last result of each frame. After a frame with tokens the window
// reads as all '-'. No clearing pass is needed after reset.
module serial_command_frame_tokenizer import scft_pkg::*; #(
  parameter int WINDOW      = WINDOW_DEF,
  parameter int TOKEN_LIMIT = TOKEN_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] error_code, [8:1] token_char,
                                  // [12:9] token_number, [13] token_end, [15:14] zero
  output logic        out_tuser,  // [0] is_error
  output logic        out_tlast   // frame_end
);

  logic             job_push_valid;
  logic             job_push_ready;
  job_t             job_push;
  logic             job_pop_valid;
  logic             job_pop_ready;
  job_t             job_pop;
  done_t            done;
  logic [PTR_W-1:0] rd_addr;
  logic [7:0]       rd_data;
  res_t             res;

  scft_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .job_valid (job_push_valid),
    .job_ready (job_push_ready),
    .job       (job_push),
    .done      (done),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  scft_jobq u_jobq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (job_push_valid),
    .push_ready (job_push_ready),
    .push_data  (job_push),
    .pop_valid  (job_pop_valid),
    .pop_ready  (job_pop_ready),
    .pop_data   (job_pop)
  );

  scft_back #(
    .WINDOW      (WINDOW),
    .TOKEN_LIMIT (TOKEN_LIMIT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_pop_valid),
    .job_ready (job_pop_ready),
    .job       (job_pop),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .done      (done),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {2'b00, res.token_end, res.token_number, res.token_char,
                      res.error_code};
  assign out_tuser = res.is_error;
  assign out_tlast = res.frame_end;

endmodule
